FILE: rtl/core/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, register indexes, phase codes and helpers for the gated
// ADSR envelope follower.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LevelW  = 17;   // Q1.16, 0 .. 65536
  localparam int unsigned CoefW   = 16;   // Q0.16
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 17;

  localparam logic [LevelW-1:0] LevelOne = 17'h10000;

  // ADSR phase codes
  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PhaseW-1:0] PH_DECAY   = 3'd2;
  localparam logic [PhaseW-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PhaseW-1:0] PH_RELEASE = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ATTACK_COEFF   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_COEFF  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ATTACK_STEP    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DECAY_STEP     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SUSTAIN_LEVEL  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_FACTOR = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_GATE_THRESHOLD = 3'd6;

  typedef struct packed {
    logic [CoefW-1:0]   attack_coeff;
    logic [CoefW-1:0]   release_coeff;
    logic [LevelW-1:0]  attack_step;
    logic [LevelW-1:0]  decay_step;
    logic [LevelW-1:0]  sustain_level;
    logic [LevelW-1:0]  release_factor;
    logic [SampleW-1:0] gate_threshold;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // take sample, start follower product
    logic fol_upd;    // update follower, start release product
    logic env_upd;    // update ADSR level and phase
    logic mix_load;   // load result registers with the shaped product
  } cmd_t;

  function automatic logic [LevelW-1:0] cap_one(input logic [LevelW:0] v);
    cap_one = (v > {1'b0, LevelOne}) ? LevelOne : v[LevelW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/adsr_cfg.sv
// ----------------------------------------------------------------------------
// adsr_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adsr_cfg (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [adsr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [adsr_pkg::CfgW-1:0]    cfg_wdata_i,
  output adsr_pkg::cfg_t              cfg_o
);
  import adsr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff   <= 16'd65534;
      cfg_q.release_coeff  <= 16'd65535;
      cfg_q.attack_step    <= 17'd7;
      cfg_q.decay_step     <= 17'd7;
      cfg_q.sustain_level  <= 17'd45875;
      cfg_q.release_factor <= 17'd65536;
      cfg_q.gate_threshold <= 16'd33;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACK_COEFF:   cfg_q.attack_coeff   <= cfg_wdata_i[CoefW-1:0];
        REG_RELEASE_COEFF:  cfg_q.release_coeff  <= cfg_wdata_i[CoefW-1:0];
        REG_ATTACK_STEP:    cfg_q.attack_step    <= cfg_wdata_i;
        REG_DECAY_STEP:     cfg_q.decay_step     <= cfg_wdata_i;
        REG_SUSTAIN_LEVEL:  cfg_q.sustain_level  <= cfg_wdata_i;
        REG_RELEASE_FACTOR: cfg_q.release_factor <= cfg_wdata_i;
        REG_GATE_THRESHOLD: cfg_q.gate_threshold <= cfg_wdata_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer: accept, follower update, envelope update, mix. Owns the
// output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adsr_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output adsr_pkg::cmd_t  cmd_o
);
  import adsr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOL  = 2'd1;
  localparam logic [1:0] S_ENV  = 2'd2;
  localparam logic [1:0] S_MIX  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.fol_upd  = (state_q == S_FOL);
    cmd_o.env_upd  = (state_q == S_ENV);
    cmd_o.mix_load = (state_q == S_MIX) && slot_free;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_FOL;
      S_FOL:  state_d = S_ENV;
      S_ENV:  state_d = S_MIX;
      S_MIX:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.mix_load) out_valid_d = 1'b1;
    else if (out_ready_i)        out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/adsr_dp.sv
// ----------------------------------------------------------------------------
// adsr_dp
// Datapath: one shared 18x18 signed multiplier, follower and ADSR state,
// result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adsr_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  adsr_pkg::cmd_t               cmd_i,
  input  adsr_pkg::cfg_t               cfg_i,
  input  wire  signed [adsr_pkg::SampleW-1:0] sample_i,
  input  wire                          block_start_i,
  output logic [adsr_pkg::LevelW-1:0]  shaped_level_o,
  output logic [adsr_pkg::LevelW-1:0]  follower_out_o,
  output logic [adsr_pkg::LevelW-1:0]  adsr_out_o,
  output logic [adsr_pkg::PhaseW-1:0]  adsr_phase_o
);
  import adsr_pkg::*;

  logic [LevelW-1:0] fol_q, adsr_q;
  logic [PhaseW-1:0] phase_q;
  logic [LevelW-1:0] m_q;
  logic              gate_q;
  logic signed [35:0] p_q;

  logic [LevelW-1:0] shaped_q, fol_out_q, adsr_out_q;
  logic [PhaseW-1:0] phase_out_q;

  // magnitude; the most negative sample maps to 1.0
  logic [SampleW-1:0] mag15;
  logic [LevelW-1:0]  mag;
  logic [CoefW-1:0]   coef;
  logic signed [LevelW:0] diff;

  assign mag15 = sample_i[SampleW-1] ? (~sample_i + 1'b1) : sample_i;
  assign mag   = {mag15, 1'b0};
  assign coef  = (mag > fol_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
  // c*L + (1-c)*m == m + c*(L-m)
  assign diff  = $signed({1'b0, fol_q}) - $signed({1'b0, mag});

  logic [LevelW-1:0] rf_cap, sus;
  assign rf_cap = cap_one({1'b0, cfg_i.release_factor});
  assign sus    = cap_one({1'b0, cfg_i.sustain_level});

  // shared multiplier
  logic signed [LevelW:0] op_a, op_b;
  logic signed [35:0]     prod;

  always_comb begin
    priority if (cmd_i.accept) begin
      op_a = diff;
      op_b = $signed({2'b00, coef});
    end else if (cmd_i.fol_upd) begin
      op_a = $signed({1'b0, adsr_q});
      op_b = $signed({1'b0, rf_cap});
    end else begin
      op_a = $signed({1'b0, fol_q});
      op_b = $signed({1'b0, adsr_q});
    end
  end

  assign prod = op_a * op_b;

  // follower update from registered product
  logic signed [LevelW+1:0] fol_sum;
  assign fol_sum = $signed({2'b00, m_q}) + $signed({p_q[33], p_q[33:16]});

  // envelope update
  logic [32:0]       rel_sum;
  logic [LevelW-1:0] rel_dec;
  logic [LevelW:0]   att_sum;
  logic [LevelW-1:0] lvl_d;
  logic [PhaseW-1:0] phase_d;

  assign rel_sum = p_q[32:0] + 33'd65535;
  assign rel_dec = rel_sum[32:16];
  assign att_sum = {1'b0, adsr_q} + {1'b0, cfg_i.attack_step};

  always_comb begin
    lvl_d   = adsr_q;
    phase_d = phase_q;
    unique case (phase_q)
      PH_ATTACK: begin
        if (att_sum >= {1'b0, LevelOne}) begin
          lvl_d   = LevelOne;
          phase_d = PH_DECAY;
        end else begin
          lvl_d = att_sum[LevelW-1:0];
        end
        if (!gate_q) phase_d = PH_RELEASE;
      end
      PH_DECAY: begin
        if ((adsr_q <= sus) || ((adsr_q - sus) <= cfg_i.decay_step)) begin
          lvl_d   = sus;
          phase_d = PH_SUSTAIN;
        end else begin
          lvl_d = adsr_q - cfg_i.decay_step;
        end
        if (!gate_q) phase_d = PH_RELEASE;
      end
      PH_SUSTAIN: begin
        lvl_d = sus;
        if (!gate_q) phase_d = PH_RELEASE;
      end
      PH_RELEASE: begin
        lvl_d = (rel_dec >= adsr_q) ? '0 : (adsr_q - rel_dec);
        if (lvl_d == '0) phase_d = PH_IDLE;
        if (gate_q)      phase_d = PH_ATTACK;
      end
      default: begin
        phase_d = gate_q ? PH_ATTACK : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fol_q   <= '0;
      adsr_q  <= '0;
      phase_q <= PH_IDLE;
    end else begin
      if (cmd_i.accept && block_start_i) begin
        adsr_q  <= '0;
        phase_q <= PH_IDLE;
      end
      if (cmd_i.fol_upd) fol_q <= cap_one(fol_sum[LevelW:0]);
      if (cmd_i.env_upd) begin
        adsr_q  <= cap_one({1'b0, lvl_d});
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      m_q    <= mag;
      gate_q <= (mag15 > cfg_i.gate_threshold);
    end
    if (cmd_i.accept || cmd_i.fol_upd) p_q <= prod;
    if (cmd_i.mix_load) begin
      shaped_q    <= prod[32:16];
      fol_out_q   <= fol_q;
      adsr_out_q  <= adsr_q;
      phase_out_q <= phase_q;
    end
  end

  assign shaped_level_o = shaped_q;
  assign follower_out_o = fol_out_q;
  assign adsr_out_o     = adsr_out_q;
  assign adsr_phase_o   = phase_out_q;

endmodule

`default_nettype wire

FILE: rtl/core/adsr_gated_envelope_follower.sv
// ----------------------------------------------------------------------------
// adsr_gated_envelope_follower
// Attack/release follower of |sample| and a gated five-phase ADSR, output as
// their clamped Q1.16 product.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o  | sample_i, block_start_i
//   out     | output    | out_valid_o/out_ready_i| shaped_level_o, follower_out_o,
//           |           |                        | adsr_out_o, adsr_phase_o
//   cfg     | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// Each sample goes through four steps (accept, follower, envelope, mix), set by the
// three dependent products going through the single shared multiplier.
// The next sample is taken the cycle after the result is loaded, even if it
// has not been drained; a stalled output holds the mix step until free.
// Reset is asynchronous, active low; levels and phase clear to zero / idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adsr_gated_envelope_follower (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [adsr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [adsr_pkg::CfgW-1:0]           cfg_wdata_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  signed [adsr_pkg::SampleW-1:0] sample_i,
  input  wire                                 block_start_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [adsr_pkg::LevelW-1:0]         shaped_level_o,
  output logic [adsr_pkg::LevelW-1:0]         follower_out_o,
  output logic [adsr_pkg::LevelW-1:0]         adsr_out_o,
  output logic [adsr_pkg::PhaseW-1:0]         adsr_phase_o
);
  import adsr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  adsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  adsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  adsr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .sample_i       (sample_i),
    .block_start_i  (block_start_i),
    .shaped_level_o (shaped_level_o),
    .follower_out_o (follower_out_o),
    .adsr_out_o     (adsr_out_o),
    .adsr_phase_o   (adsr_phase_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/adsr_checker.sv
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks on the envelope follower, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adsr_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_ready_o,
  input wire  signed [adsr_pkg::SampleW-1:0] sample_i,
  input wire                                 block_start_i,
  input wire                                 out_valid_o,
  input wire                                 out_ready_i,
  input wire  [adsr_pkg::LevelW-1:0]         shaped_level_o,
  input wire  [adsr_pkg::LevelW-1:0]         follower_out_o,
  input wire  [adsr_pkg::LevelW-1:0]         adsr_out_o,
  input wire  [adsr_pkg::PhaseW-1:0]         adsr_phase_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // waiting sample holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_i)
      && $stable(block_start_i))
    else $error("sample changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(shaped_level_o)
      && $stable(follower_out_o) && $stable(adsr_out_o) && $stable(adsr_phase_o))
    else $error("result changed while stalled");

  // envelope never exceeds 1.0, so the product never exceeds the follower
  a_shaped_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shaped_level_o <= follower_out_o)
    else $error("shaped level above follower level");

  // one sample in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while busy");

  // no new result sooner than the mix step
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind adsr_gated_envelope_follower adsr_checker u_adsr_checker (.*);

`default_nettype wire

FILE: tb/adsr_envelope_checker.sv
// ----------------------------------------------------------------------------
// adsr_envelope_checker
// Watches the register port and both streaming channels of the gated ADSR
// envelope follower. Keeps its own follower and ADSR state, predicts each
// result and compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_envelope_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adsr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [adsr_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [adsr_pkg::SampleW-1:0] sample_i,
  input  logic                                block_start_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [adsr_pkg::LevelW-1:0]         shaped_level_i,
  input  logic [adsr_pkg::LevelW-1:0]         follower_out_i,
  input  logic [adsr_pkg::LevelW-1:0]         adsr_out_i,
  input  logic [adsr_pkg::PhaseW-1:0]         adsr_phase_i,
  output int                                  outstanding_o,
  output int                                  failures_o
);

  import adsr_pkg::*;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [PhaseW-1:0] phase;
  } envelope_state_t;

  typedef struct packed {
    logic [LevelW-1:0] shaped;
    logic [LevelW-1:0] follower;
    logic [LevelW-1:0] envelope;
    logic [PhaseW-1:0] phase;
  } level_set_t;

  // register copies
  logic [CoefW-1:0]   rise_coeff   = 16'd65534;
  logic [CoefW-1:0]   fall_coeff   = 16'd65535;
  logic [LevelW-1:0]  atk_step     = 17'd7;
  logic [LevelW-1:0]  dec_step     = 17'd7;
  logic [LevelW-1:0]  sus_level    = 17'd45875;
  logic [LevelW-1:0]  rel_factor   = 17'd65536;
  logic [SampleW-1:0] gate_thr     = 16'd33;

  logic [LevelW-1:0] follower_lvl = '0;
  envelope_state_t   env_state    = '0;
  level_set_t        predicted_levels[$];
  int                failures     = 0;

  function automatic logic [LevelW-1:0] clamp_unity(input logic [33:0] v);
    return (v > 34'h10000) ? LevelOne : v[LevelW-1:0];
  endfunction

  // one-pole follower; products truncate, result saturates at 1.0
  function automatic logic [LevelW-1:0] follow_magnitude(input logic [LevelW-1:0] lvl,
                                                         input logic [LevelW-1:0] mag);
    logic [CoefW-1:0] c;
    logic [40:0]      acc;
    c   = (mag > lvl) ? rise_coeff : fall_coeff;
    acc = 41'(c) * 41'(lvl) + (41'h10000 - 41'(c)) * 41'(mag);
    return clamp_unity(34'(acc[40:16]));
  endfunction

  function automatic envelope_state_t advance_envelope(input envelope_state_t cur,
                                                       input logic gate);
    logic [31:0]       lvl;
    logic [LevelW-1:0] sus;
    logic [LevelW-1:0] rel;
    logic [33:0]       prod;
    logic [33:0]       dec;
    envelope_state_t   nxt;
    sus       = clamp_unity(34'(sus_level));
    rel       = clamp_unity(34'(rel_factor));
    lvl       = 32'(cur.level);
    nxt.phase = cur.phase;
    case (cur.phase)
      PH_ATTACK: begin
        lvl = lvl + 32'(atk_step);
        if (lvl >= 32'h10000) begin
          lvl       = 32'h10000;
          nxt.phase = PH_DECAY;
        end
        if (!gate) nxt.phase = PH_RELEASE;
      end
      PH_DECAY: begin
        if (lvl <= 32'(sus) || (lvl - 32'(sus)) <= 32'(dec_step)) begin
          lvl       = 32'(sus);
          nxt.phase = PH_SUSTAIN;
        end else begin
          lvl = lvl - 32'(dec_step);
        end
        if (!gate) nxt.phase = PH_RELEASE;
      end
      PH_SUSTAIN: begin
        lvl = 32'(sus);
        if (!gate) nxt.phase = PH_RELEASE;
      end
      PH_RELEASE: begin
        // decrement rounds up so any nonzero release factor gets the level to zero
        prod = 34'(lvl[LevelW-1:0]) * 34'(rel);
        dec  = (prod + 34'd65535) >> 16;
        lvl  = (dec >= 34'(lvl)) ? 32'd0 : lvl - dec[31:0];
        if (lvl == 0) nxt.phase = PH_IDLE;
        if (gate) nxt.phase = PH_ATTACK;
      end
      default: begin
        nxt.phase = gate ? PH_ATTACK : PH_IDLE;
      end
    endcase
    nxt.level = clamp_unity(34'(lvl));
    return nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [LevelW-1:0] mag15;
    logic [33:0]       prod;
    level_set_t        want;
    level_set_t        got;
    if (!rst_ni) begin
      rise_coeff   = 16'd65534;
      fall_coeff   = 16'd65535;
      atk_step     = 17'd7;
      dec_step     = 17'd7;
      sus_level    = 17'd45875;
      rel_factor   = 17'd65536;
      gate_thr     = 16'd33;
      follower_lvl = '0;
      env_state    = '0;
      predicted_levels.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATTACK_COEFF:   rise_coeff = cfg_wdata_i[CoefW-1:0];
          REG_RELEASE_COEFF:  fall_coeff = cfg_wdata_i[CoefW-1:0];
          REG_ATTACK_STEP:    atk_step   = cfg_wdata_i;
          REG_DECAY_STEP:     dec_step   = cfg_wdata_i;
          REG_SUSTAIN_LEVEL:  sus_level  = cfg_wdata_i;
          REG_RELEASE_FACTOR: rel_factor = cfg_wdata_i;
          REG_GATE_THRESHOLD: gate_thr   = cfg_wdata_i[SampleW-1:0];
          default: ;
        endcase
      end

      // result side first: it always belongs to an older transaction
      if (out_valid_i && out_ready_i) begin
        got = '{shaped_level_i, follower_out_i, adsr_out_i, adsr_phase_i};
        if (predicted_levels.size() == 0) begin
          $error("result transaction with nothing outstanding");
          failures++;
        end else begin
          want = predicted_levels.pop_front();
          if (got.shaped !== want.shaped) begin
            $error("shaped_level: expected %0d, actual %0d", want.shaped, got.shaped);
            failures++;
          end
          if (got.follower !== want.follower) begin
            $error("follower_out: expected %0d, actual %0d", want.follower, got.follower);
            failures++;
          end
          if (got.envelope !== want.envelope) begin
            $error("adsr_out: expected %0d, actual %0d", want.envelope, got.envelope);
            failures++;
          end
          if (got.phase !== want.phase) begin
            $error("adsr_phase: expected %0d, actual %0d", want.phase, got.phase);
            failures++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        mag15 = sample_i[SampleW-1] ? (17'h10000 - {1'b0, sample_i}) : {1'b0, sample_i};
        if (block_start_i) begin
          env_state.level = '0;
          env_state.phase = PH_IDLE;
        end
        follower_lvl = follow_magnitude(follower_lvl, mag15 << 1);
        env_state    = advance_envelope(env_state, mag15 > {1'b0, gate_thr});
        prod         = 34'(follower_lvl) * 34'(env_state.level);
        want = '{prod[32:16], follower_lvl, env_state.level, env_state.phase};
        predicted_levels.push_back(want);
      end
      outstanding_o <= predicted_levels.size();
    end
    failures_o <= failures;
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the gated ADSR envelope follower: directed
// extremes, then gated note patterns and noise under random register
// settings, with random gaps on the sample side and stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import adsr_pkg::*;

  localparam int StallLimit = 5000;
  localparam int Settings   = 6;
  localparam int PerSetting = 85;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic                 block_start_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [LevelW-1:0]    shaped_level_o;
  logic [LevelW-1:0]    follower_out_o;
  logic [LevelW-1:0]    adsr_out_o;
  logic [PhaseW-1:0]    adsr_phase_o;

  int outstanding;
  int failures;
  int sent_count    = 0;
  int results_seen  = 0;
  int stuck         = 0;
  int settings_used = 0;
  bit steady        = 1'b0;
  logic [LevelW-1:0] gate_thr = 17'd33;

  adsr_gated_envelope_follower i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .block_start_i  (block_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shaped_level_o (shaped_level_o),
    .follower_out_o (follower_out_o),
    .adsr_out_o     (adsr_out_o),
    .adsr_phase_o   (adsr_phase_o)
  );

  adsr_envelope_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_i),
    .block_start_i  (block_start_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shaped_level_i (shaped_level_o),
    .follower_out_i (follower_out_o),
    .adsr_out_i     (adsr_out_o),
    .adsr_phase_i   (adsr_phase_o),
    .outstanding_o  (outstanding),
    .failures_o     (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CfgW-1:0] rand_setting(input logic [CfgIdxW-1:0] idx);
    logic [CfgW-1:0] v;
    logic [CfgW-1:0] edge_val;
    case ($urandom_range(2))
      0:       edge_val = 17'd0;
      1:       edge_val = 17'd65536;
      default: edge_val = 17'd131071;
    endcase
    case (idx)
      REG_ATTACK_COEFF, REG_RELEASE_COEFF: begin
        v = 17'($urandom_range(65535));
        if ($urandom_range(3) == 0) v = $urandom_range(1) ? 17'd65535 : 17'd0;
      end
      REG_ATTACK_STEP, REG_DECAY_STEP: begin
        v = 17'($urandom_range(30000, 1500));
        if ($urandom_range(7) == 0) v = edge_val;
      end
      REG_SUSTAIN_LEVEL: begin
        v = 17'($urandom_range(65536));
        if ($urandom_range(7) == 0) v = edge_val;
      end
      REG_RELEASE_FACTOR: begin
        v = 17'($urandom_range(40000, 1000));
        if ($urandom_range(7) == 0) v = edge_val;
      end
      default: begin
        v = 17'($urandom_range(20000));
        if ($urandom_range(7) == 0) v = $urandom_range(1) ? 17'd32768 : 17'd0;
      end
    endcase
    return v;
  endfunction

  // magnitude above or at/below the gate threshold, random sign
  function automatic logic [SampleW-1:0] make_sample(input bit loud);
    logic [LevelW-1:0] mag;
    if (loud && gate_thr < 32768) mag = 17'($urandom_range(32768, gate_thr + 1));
    else                          mag = 17'($urandom_range(gate_thr));
    if (mag == 32768) return 16'h8000;
    return $urandom_range(1) ? -mag[SampleW-1:0] : mag[SampleW-1:0];
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic program_all(input logic [CfgW-1:0] a_coef, input logic [CfgW-1:0] r_coef,
                             input logic [CfgW-1:0] a_step, input logic [CfgW-1:0] d_step,
                             input logic [CfgW-1:0] sus,    input logic [CfgW-1:0] r_fact,
                             input logic [CfgW-1:0] thr);
    write_reg(REG_ATTACK_COEFF,   a_coef);
    write_reg(REG_RELEASE_COEFF,  r_coef);
    write_reg(REG_ATTACK_STEP,    a_step);
    write_reg(REG_DECAY_STEP,     d_step);
    write_reg(REG_SUSTAIN_LEVEL,  sus);
    write_reg(REG_RELEASE_FACTOR, r_fact);
    write_reg(REG_GATE_THRESHOLD, thr);
    cfg_we_i <= 1'b0;
    gate_thr = {1'b0, thr[SampleW-1:0]};
    settings_used++;
  endtask

  task automatic send_sample(input logic [SampleW-1:0] value, input logic start);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= value;
    block_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // gate on for a while, then off; a few samples land on the wrong side
  task automatic play_note();
    int  hold;
    int  rest;
    bit  first_start;
    hold        = $urandom_range(40, 1);
    rest        = $urandom_range(30, 1);
    first_start = ($urandom_range(2) == 0);
    for (int i = 0; i < hold; i++)
      send_sample(make_sample($urandom_range(9) != 0), first_start && i == 0);
    for (int i = 0; i < rest; i++)
      send_sample(make_sample($urandom_range(9) == 0), 1'b0);
  endtask

  task automatic play_noise();
    int n;
    n = $urandom_range(10, 1);
    for (int i = 0; i < n; i++)
      send_sample(16'($urandom), $urandom_range(7) == 0);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 70) play_note();
      else                         play_noise();
      if ($urandom_range(99) < 3) wait_idle();
    end
  endtask

  // result side back-pressure
  initial begin : result_side
    int run;
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = steady ? 16 : $urandom_range(20, 1);
      repeat (run) @(posedge clk_i);
      stall = steady ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles without any transaction or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) stuck = 0;
    else stuck++;
    if (out_valid_o && out_ready_i) results_seen++;
    if (stuck >= StallLimit) begin
      $display("adsr_gated_envelope_follower: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_ATTACK_COEFF;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    sample_i      <= '0;
    block_start_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: sample extremes and the gate threshold boundary
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd33, 1'b0);
    send_sample(16'sd34, 1'b0);
    send_sample(-16'sd34, 1'b1);
    wait_idle();

    // instant follower, one-step attack and decay, zero sustain, full release
    program_all(17'd0, 17'd0, 17'd65536, 17'd65536, 17'd0, 17'd65536, 17'd0);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    wait_idle();

    // registers above 1.0, slowest follower poles
    program_all(17'd65535, 17'd65535, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd32767, 1'b0);
    wait_idle();

    for (int p = 0; p < Settings; p++) begin
      program_all(rand_setting(REG_ATTACK_COEFF), rand_setting(REG_RELEASE_COEFF),
                  rand_setting(REG_ATTACK_STEP), rand_setting(REG_DECAY_STEP),
                  rand_setting(REG_SUSTAIN_LEVEL), rand_setting(REG_RELEASE_FACTOR),
                  rand_setting(REG_GATE_THRESHOLD));
      steady = (p == 2);
      run_random(PerSetting);
      wait_idle();
      steady = 1'b0;
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d samples under %0d register settings; %0d results compared,",
             sent_count, settings_used + 1, results_seen);
    $display("with random gaps and stalls on both channels and one stall-free setting.");
    if (failures == 0) begin
      $display("adsr_gated_envelope_follower: match");
    end else begin
      $display("adsr_gated_envelope_follower: mismatch");
    end
    $finish;
  end

endmodule
